// ===== hdl/varr_pkg.sv =====
// Shared constants for the axis-angle vector rotation core.
// Q2.30 angle constants, CORDIC arctangent table and default parameter values.
// No dependencies.
package varr_pkg;

  localparam int DATA_WIDTH_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam logic [15:0] ZSNAP_RESET = 16'd7;
  // squared axis length (Q32.32) at or below this counts as a zero axis
  localparam logic [8:0]  DEGEN_LIMIT = 9'd42;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [29:0] CORDIC_X0   = 30'd652032874;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

endpackage

// ===== hdl/vector_axis_angle_rotate_core.sv =====
// Axis-angle (Rodrigues) rotation of a Q16.16 vector, fully pipelined.
// Depends on varr_pkg.
//
// Takes one request per clock and returns one result per request, in order.
// The axis path sets the pipeline depth: 6 stages of magnitude/normalise/
// square, 16 stages of square root (two result bits per stage), 16 stages
// for the three unit-axis divisions (two quotient bits per stage), one sign
// stage, then 7 stages of products, sums, rounding, saturation and zero snap.
// The angle path (modulo 2*pi reduction and CORDIC at two iterations per
// stage) runs alongside and is delayed to match. A stall on the output side
// holds the whole pipeline; nothing is lost.
module vector_axis_angle_rotate_core
  import varr_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle (32 bits each)
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z (32 bits each)
  output logic [95:0]  m_axis_tdata,
  // degenerate_axis
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  localparam int EW     = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int NSTEP  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int NCS    = (NSTEP + 1) / 2;
  localparam int RED_ST = 7;
  localparam int SQ_ST  = 16;
  localparam int DIV_ST = 16;
  localparam int LA     = 6 + SQ_ST + DIV_ST + 1;
  localparam int LB     = 1 + RED_ST + 1 + NCS + 1;
  localparam int ADLY   = LA - LB;
  localparam int LAT    = LA + 8;

  localparam logic signed [35:0] PI_S    = 36'(PI_Q30);
  localparam logic signed [35:0] TWOPI_S = 36'(TWO_PI_Q30);
  localparam logic signed [35:0] HALF_S  = 36'(HALF_PI_Q30);
  localparam logic signed [33:0] ONE_X   = 34'(ONE_Q30);
  localparam logic signed [32:0] ONE_S   = 33'(ONE_Q30);
  localparam logic signed [43:0] SMAX    = 44'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [43:0] SMIN    = -SMAX - 44'sd1;

  function automatic logic signed [31:0] sx(input logic [31:0] f);
    sx = $signed(f << (32 - EW)) >>> (32 - EW);
  endfunction

  logic [15:0]    thr;
  logic           ce;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ZSNAP_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  assign ce            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [31:0] v0 [3];
  logic signed [31:0] a0 [3];
  logic signed [31:0] ang0;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        v0[i] <= sx(s_axis_tdata[32*i +: 32]);
        a0[i] <= sx(s_axis_tdata[96 + 32*i +: 32]);
      end
      ang0 <= sx(s_axis_tdata[223:192]);
    end
  end

  // ---------------- axis path: magnitudes and zero-axis test ----------------
  logic [31:0] am_c [3];
  logic [8:0]  ssum_c;
  logic        big_c;

  always_comb begin
    ssum_c = '0;
    big_c  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      am_c[i] = a0[i][31] ? 32'(-a0[i]) : 32'(a0[i]);
      if (am_c[i] > 32'd6) big_c = 1'b1;
      ssum_c = ssum_c + 9'(am_c[i][2:0]) * 9'(am_c[i][2:0]);
    end
  end

  logic [31:0] am1 [3];
  logic [2:0]  neg1;
  logic        dg1;
  logic [31:0] am2 [3];
  logic [2:0]  neg2;
  logic        dg2;
  logic [31:0] max2;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        am1[i]  <= am_c[i];
        neg1[i] <= a0[i][31];
      end
      dg1 <= !big_c && (ssum_c <= DEGEN_LIMIT);
      am2  <= am1;
      neg2 <= neg1;
      dg2  <= dg1;
      if (am1[0] >= am1[1] && am1[0] >= am1[2]) max2 <= am1[0];
      else if (am1[1] >= am1[2])                max2 <= am1[1];
      else                                      max2 <= am1[2];
    end
  end

  // leading one of the largest magnitude; scale it into [2^29, 2^30)
  logic [4:0] msb_c;
  always_comb begin
    msb_c = '0;
    for (int j = 0; j < 32; j++) begin
      if (max2[j]) msb_c = 5'(j);
    end
  end

  logic [31:0] am3 [3];
  logic [2:0]  neg3;
  logic        dg3;
  logic [4:0]  lsh3;
  logic [1:0]  rsh3;
  logic [29:0] bm4 [3];
  logic [2:0]  neg4;
  logic        dg4;
  logic [59:0] bq5 [3];
  logic [29:0] bm5 [3];
  logic [2:0]  neg5;
  logic        dg5;
  logic [61:0] sq6;
  logic [29:0] bm6 [3];
  logic [2:0]  neg6;
  logic        dg6;

  always_ff @(posedge clk) begin
    if (ce) begin
      am3  <= am2;
      neg3 <= neg2;
      dg3  <= dg2;
      lsh3 <= (msb_c < 5'd29) ? 5'd29 - msb_c : 5'd0;
      rsh3 <= (msb_c > 5'd29) ? 2'(msb_c - 5'd29) : 2'd0;
      for (int i = 0; i < 3; i++) begin
        bm4[i] <= 30'((am3[i] << lsh3) >> rsh3);
        bq5[i] <= 60'(bm4[i]) * 60'(bm4[i]);
      end
      neg4 <= neg3;
      dg4  <= dg3;
      bm5  <= bm4;
      neg5 <= neg4;
      dg5  <= dg4;
      sq6  <= 62'(bq5[0]) + 62'(bq5[1]) + 62'(bq5[2]);
      bm6  <= bm5;
      neg6 <= neg5;
      dg6  <= dg5;
    end
  end

  // ---------------- integer square root, two bits per stage ----------------
  logic [63:0] sn [SQ_ST+1];
  logic [63:0] sr [SQ_ST+1];
  logic [29:0] sbm [SQ_ST+1][3];
  logic [2:0]  sneg [SQ_ST+1];
  logic        sdg [SQ_ST+1];

  assign sn[0]   = {2'b00, sq6};
  assign sr[0]   = '0;
  assign sbm[0]  = bm6;
  assign sneg[0] = neg6;
  assign sdg[0]  = dg6;

  for (genvar s = 1; s <= SQ_ST; s++) begin : g_sqrt
    logic [63:0] n_c;
    logic [63:0] r_c;
    logic [63:0] b_c;
    always_comb begin
      n_c = sn[s-1];
      r_c = sr[s-1];
      for (int j = 0; j < 2; j++) begin
        b_c = 64'd1 << (62 - 2 * (2 * (s - 1) + j));
        if (n_c >= r_c + b_c) begin
          n_c = n_c - (r_c + b_c);
          r_c = (r_c >> 1) + b_c;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        sn[s]   <= n_c;
        sr[s]   <= r_c;
        sbm[s]  <= sbm[s-1];
        sneg[s] <= sneg[s-1];
        sdg[s]  <= sdg[s-1];
      end
    end
  end

  // ---------------- unit axis: (bm << 30) / len, two bits per stage ----------------
  logic [62:0] dr [DIV_ST+1][3];
  logic [30:0] dq [DIV_ST+1][3];
  logic [31:0] dl [DIV_ST+1];
  logic [2:0]  dneg [DIV_ST+1];
  logic        ddg [DIV_ST+1];

  for (genvar i = 0; i < 3; i++) begin : g_div0
    assign dr[0][i] = 63'(sbm[SQ_ST][i]) << 30;
    assign dq[0][i] = '0;
  end
  assign dl[0]   = sr[SQ_ST][31:0];
  assign dneg[0] = sneg[SQ_ST];
  assign ddg[0]  = sdg[SQ_ST];

  for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
    logic [62:0] rem_c [3];
    logic [30:0] q_c [3];
    logic [62:0] dv_c;
    int          k;
    always_comb begin
      dv_c = '0;
      k    = 0;
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = dr[s-1][i];
        q_c[i]   = dq[s-1][i];
        for (int j = 0; j < 2; j++) begin
          k = 30 - 2 * (s - 1) - j;
          if (k >= 0) begin
            dv_c = 63'(dl[s-1]) << k;
            if (rem_c[i] >= dv_c) begin
              rem_c[i] = rem_c[i] - dv_c;
              q_c[i]   = {q_c[i][29:0], 1'b1};
            end else begin
              q_c[i]   = {q_c[i][29:0], 1'b0};
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dr[s]   <= rem_c;
        dq[s]   <= q_c;
        dl[s]   <= dl[s-1];
        dneg[s] <= dneg[s-1];
        ddg[s]  <= ddg[s-1];
      end
    end
  end

  logic signed [31:0] ua [3];
  logic               dga;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (ddg[DIV_ST])         ua[i] <= '0;
        else if (dneg[DIV_ST][i]) ua[i] <= -$signed({1'b0, dq[DIV_ST][i]});
        else                     ua[i] <= $signed({1'b0, dq[DIV_ST][i]});
      end
      dga <= ddg[DIV_ST];
    end
  end

  // ---------------- angle path: reduction modulo 2*pi ----------------
  logic [47:0] rd [RED_ST+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      // offset by 2*pi*2^13 so the value is non-negative
      rd[0] <= 48'($signed({ang0, 14'b0})) + (48'(TWO_PI_Q30) << 13);
    end
  end

  for (genvar s = 1; s <= RED_ST; s++) begin : g_red
    logic [47:0] r_c;
    logic [47:0] m_c;
    always_comb begin
      r_c = rd[s-1];
      m_c = '0;
      for (int j = 0; j < 2; j++) begin
        m_c = 48'(TWO_PI_Q30) << (13 - 2 * (s - 1) - j);
        if (r_c >= m_c) r_c = r_c - m_c;
      end
    end
    always_ff @(posedge clk) begin
      if (ce) rd[s] <= r_c;
    end
  end

  // map to (-pi, pi], fold into [-pi/2, pi/2]
  logic signed [35:0] fz_c;
  logic               ff_c;
  always_comb begin
    fz_c = $signed({2'b00, rd[RED_ST][33:0]});
    ff_c = 1'b0;
    if (fz_c > PI_S) fz_c = fz_c - TWOPI_S;
    if (fz_c > HALF_S) begin
      fz_c = fz_c - PI_S;
      ff_c = 1'b1;
    end else if (fz_c < -HALF_S) begin
      fz_c = fz_c + PI_S;
      ff_c = 1'b1;
    end
  end

  logic signed [33:0] cx [NCS+1];
  logic signed [33:0] cy [NCS+1];
  logic signed [35:0] cz [NCS+1];
  logic               cf [NCS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      cx[0] <= 34'(CORDIC_X0);
      cy[0] <= '0;
      cz[0] <= fz_c;
      cf[0] <= ff_c;
    end
  end

  for (genvar s = 1; s <= NCS; s++) begin : g_cordic
    logic signed [33:0] x_c;
    logic signed [33:0] y_c;
    logic signed [33:0] nx_c;
    logic signed [35:0] z_c;
    logic signed [35:0] at_c;
    int                 it;
    always_comb begin
      x_c  = cx[s-1];
      y_c  = cy[s-1];
      z_c  = cz[s-1];
      nx_c = '0;
      at_c = '0;
      it   = 0;
      for (int j = 0; j < 2; j++) begin
        it = 2 * (s - 1) + j;
        if (it < NSTEP) begin
          at_c = $signed({6'b0, ATAN_Q30[it]});
          if (!z_c[35]) begin
            nx_c = x_c - (y_c >>> it);
            y_c  = y_c + (x_c >>> it);
            z_c  = z_c - at_c;
          end else begin
            nx_c = x_c + (y_c >>> it);
            y_c  = y_c - (x_c >>> it);
            z_c  = z_c + at_c;
          end
          x_c = nx_c;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        cx[s] <= x_c;
        cy[s] <= y_c;
        cz[s] <= z_c;
        cf[s] <= cf[s-1];
      end
    end
  end

  logic signed [33:0] fx_c;
  logic signed [33:0] fy_c;
  always_comb begin
    fx_c = cf[NCS] ? -cx[NCS] : cx[NCS];
    fy_c = cf[NCS] ? -cy[NCS] : cy[NCS];
    if (fx_c > ONE_X)  fx_c = ONE_X;
    if (fx_c < -ONE_X) fx_c = -ONE_X;
    if (fy_c > ONE_X)  fy_c = ONE_X;
    if (fy_c < -ONE_X) fy_c = -ONE_X;
  end

  logic signed [31:0] sd [ADLY+1];
  logic signed [31:0] cd [ADLY+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= 32'(fy_c);
      cd[0] <= 32'(fx_c);
      for (int i = 1; i <= ADLY; i++) begin
        sd[i] <= sd[i-1];
        cd[i] <= cd[i-1];
      end
    end
  end

  // vector delay to meet the unit axis
  logic signed [31:0] vd [1:LA][3];

  always_ff @(posedge clk) begin
    if (ce) begin
      vd[1] <= v0;
      for (int i = 2; i <= LA; i++) vd[i] <= vd[i-1];
    end
  end

  // ---------------- Rodrigues combination ----------------
  logic signed [63:0] pc1 [3];
  logic signed [63:0] pa1 [3];
  logic signed [63:0] pb1 [3];
  logic signed [63:0] pd1 [3];
  logic signed [31:0] u1 [3];
  logic signed [31:0] s1;
  logic signed [31:0] c1;
  logic               dg_1;

  logic signed [35:0] cr2 [3];
  logic signed [35:0] d2;
  logic signed [61:0] cv2 [3];
  logic signed [32:0] oc2;
  logic signed [31:0] u2 [3];
  logic signed [31:0] s2;
  logic               dg_2;

  logic signed [69:0] ps3 [3];
  logic signed [69:0] pe3;
  logic signed [61:0] cv3 [3];
  logic signed [31:0] u3 [3];
  logic               dg_3;

  logic signed [39:0] e4;
  logic signed [67:0] sc4 [3];
  logic signed [61:0] cv4 [3];
  logic signed [31:0] u4 [3];
  logic               dg_4;

  logic signed [71:0] pu5 [3];
  logic signed [67:0] sc5 [3];
  logic signed [61:0] cv5 [3];
  logic               dg_5;

  logic signed [71:0] sm6 [3];
  logic               dg_6;

  logic signed [31:0] res7 [3];
  logic               dg_7;

  // round, saturate, snap small values to zero
  logic signed [31:0] res_c [3];
  logic signed [43:0] rr_c [3];
  logic        [43:0] rm_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr_c[i] = 44'((sm6[i] + 72'sd134217728) >>> 28);
      if (rr_c[i] > SMAX)      rr_c[i] = SMAX;
      else if (rr_c[i] < SMIN) rr_c[i] = SMIN;
      rm_c[i]  = rr_c[i][43] ? 44'(-rr_c[i]) : 44'(rr_c[i]);
      res_c[i] = (rm_c[i] < 44'(thr)) ? 32'sd0 : 32'(rr_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        pc1[i] <= cd[ADLY] * vd[LA][i];
        pa1[i] <= ua[(i+1)%3] * vd[LA][(i+2)%3];
        pb1[i] <= ua[(i+2)%3] * vd[LA][(i+1)%3];
        pd1[i] <= ua[i] * vd[LA][i];
      end
      u1   <= ua;
      s1   <= sd[ADLY];
      c1   <= cd[ADLY];
      dg_1 <= dga;

      for (int i = 0; i < 3; i++) begin
        cr2[i] <= 36'((pa1[i] - pb1[i]) >>> 30);
        cv2[i] <= 62'(pc1[i] >>> 2);
      end
      d2   <= 36'(((pd1[0] >>> 2) + (pd1[1] >>> 2) + (pd1[2] >>> 2)) >>> 28);
      oc2  <= ONE_S - 33'(c1);
      u2   <= u1;
      s2   <= s1;
      dg_2 <= dg_1;

      for (int i = 0; i < 3; i++) ps3[i] <= s2 * cr2[i];
      pe3  <= d2 * oc2;
      cv3  <= cv2;
      u3   <= u2;
      dg_3 <= dg_2;

      e4 <= 40'(pe3 >>> 30);
      for (int i = 0; i < 3; i++) sc4[i] <= 68'(ps3[i] >>> 2);
      cv4  <= cv3;
      u4   <= u3;
      dg_4 <= dg_3;

      for (int i = 0; i < 3; i++) pu5[i] <= u4[i] * e4;
      sc5  <= sc4;
      cv5  <= cv4;
      dg_5 <= dg_4;

      for (int i = 0; i < 3; i++) begin
        sm6[i] <= 72'(cv5[i]) + 72'(sc5[i]) + (pu5[i] >>> 2);
      end
      dg_6 <= dg_5;

      res7 <= res_c;
      dg_7 <= dg_6;
    end
  end

  assign m_axis_tdata = {res7[2], res7[1], res7[0]};
  assign m_axis_tuser = dg_7;

endmodule
